### rtl/dca_pkg.sv
// Shared types and constants for the DMA channel allocator.
// Holds the request and result payload structs and the fixed channel table.
// No dependencies.
package dca_pkg;

    localparam int CHAN_COUNT = 8;
    localparam int CHAN_W     = 3;
    localparam int CAPS_W     = 3;
    localparam int USE_W      = 4;
    localparam int CFG_W      = 4;

    localparam logic [CFG_W-1:0] PRESENT_MIN   = 4'd4;
    localparam logic [CFG_W-1:0] PRESENT_MAX   = 4'd8;
    localparam logic [CFG_W-1:0] PRESENT_RESET = 4'd4;

    // Operation codes.
    localparam logic OP_OPEN  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // Status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    // Channel use word: bit 0 in use, bits 3:1 the recorded pins.
    localparam logic [USE_W-1:0] USE_BUSY = 4'h1;
    localparam logic [USE_W-1:0] USE_REQ  = 4'h2;
    localparam logic [USE_W-1:0] USE_ACK  = 4'h4;
    localparam logic [USE_W-1:0] USE_DONE = 4'h8;

    // Capability bits in request encoding.
    localparam logic [CAPS_W-1:0] CAP_REQ  = 3'h1;
    localparam logic [CAPS_W-1:0] CAP_ACK  = 3'h2;
    localparam logic [CAPS_W-1:0] CAP_DONE = 3'h4;
    localparam logic [CAPS_W-1:0] CAP_ALL  = CAP_REQ | CAP_ACK | CAP_DONE;

    typedef logic [CHAN_COUNT-1:0][USE_W-1:0] use_map_t;

    typedef struct packed {
        logic              op;
        logic [7:0]        channel_mask;
        logic [CAPS_W-1:0] want_caps;
        logic [CHAN_W-1:0] close_channel;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [CHAN_W-1:0] granted_channel;
        logic [7:0]        busy_map;
    } rsp_t;

    function automatic logic [CAPS_W-1:0] chan_caps(input logic [CHAN_W-1:0] ch);
        logic [CAPS_W-1:0] caps;
        case (ch)
            3'd0, 3'd1: caps = CAP_ALL;
            3'd2, 3'd3: caps = CAP_REQ | CAP_ACK;
            default:    caps = CAP_REQ;
        endcase
        return caps;
    endfunction

    // Partners pair channel i with channel i+4.
    function automatic logic [CHAN_W-1:0] chan_partner(input logic [CHAN_W-1:0] ch);
        return ch ^ 3'd4;
    endfunction

    function automatic logic [CAPS_W-1:0] chan_clash_want(input logic [CHAN_W-1:0] ch);
        logic [CAPS_W-1:0] w;
        case (ch)
            3'd0, 3'd1: w = CAP_DONE;
            3'd2, 3'd3: w = CAP_ACK;
            default:    w = CAP_REQ;
        endcase
        return w;
    endfunction

    function automatic logic [USE_W-1:0] chan_clash_use(input logic [CHAN_W-1:0] ch);
        logic [USE_W-1:0] u;
        case (ch)
            3'd0, 3'd1, 3'd2, 3'd3: u = USE_REQ;
            3'd4, 3'd5:             u = USE_DONE;
            default:                u = USE_ACK;
        endcase
        return u;
    endfunction

endpackage

### rtl/dca_select.sv
// Channel qualification, priority pick and next channel-use state for one request.
// Purely combinational; depends on dca_pkg.
module dca_select (
    input  dca_pkg::req_t               req,
    input  dca_pkg::use_map_t           use_map,
    input  logic [dca_pkg::CFG_W-1:0]   present_cfg,
    output dca_pkg::use_map_t           use_next,
    output dca_pkg::rsp_t               rsp
);
    import dca_pkg::*;

    logic [CFG_W-1:0]      present_n;
    logic [CHAN_COUNT-1:0] qual;
    logic                  found;
    logic [CHAN_W-1:0]     pick;
    logic [CHAN_W-1:0]     ch;
    logic [CHAN_W-1:0]     partner;

    // Out-of-range register values saturate to the legal range.
    always_comb begin
        if (present_cfg < PRESENT_MIN) begin
            present_n = PRESENT_MIN;
        end else if (present_cfg > PRESENT_MAX) begin
            present_n = PRESENT_MAX;
        end else begin
            present_n = present_cfg;
        end
    end

    always_comb begin
        for (int i = 0; i < CHAN_COUNT; i++) begin
            ch      = CHAN_W'(i);
            partner = chan_partner(ch);
            qual[i] = req.channel_mask[i]
                    && ((chan_caps(ch) & req.want_caps) == req.want_caps)
                    && ({1'b0, ch} < present_n)
                    && (use_map[i] == '0)
                    && !(((req.want_caps & chan_clash_want(ch)) != '0)
                         && ((use_map[partner] & chan_clash_use(ch)) != '0));
        end
    end

    // Highest qualifying channel wins.
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = CHAN_COUNT - 1; i >= 0; i--) begin
            if (!found && qual[i]) begin
                found = 1'b1;
                pick  = CHAN_W'(i);
            end
        end
    end

    always_comb begin
        use_next            = use_map;
        rsp.status          = STATUS_OK;
        rsp.granted_channel = '0;
        if (req.op == OP_OPEN) begin
            if (found) begin
                use_next[pick]      = USE_BUSY | {req.want_caps, 1'b0};
                rsp.granted_channel = pick;
            end else begin
                rsp.status = STATUS_NO_SPACE;
            end
        end else begin
            if ({1'b0, req.close_channel} < present_n) begin
                use_next[req.close_channel] = '0;
            end
        end
        for (int i = 0; i < CHAN_COUNT; i++) begin
            rsp.busy_map[i] = use_next[i][0];
        end
    end

endmodule

### rtl/dma_channel_allocator_core.sv
// DMA channel allocator top level: input register, allocation logic, result register.
// A request is held in the input register, then resolved into the result register;
// throughput is one request per cycle while m_ready does not stall the result register.
// Synchronous active-low reset frees all channels and sets present_channels to 4.
// Depends on dca_pkg and dca_select.
module dma_channel_allocator_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [dca_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dca_pkg::req_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dca_pkg::rsp_t               m_data
);
    import dca_pkg::*;

    logic             present_reg;
    logic [CFG_W-1:0] present_cfg_reg;
    logic             in_valid_reg;
    req_t             in_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;
    use_map_t         use_reg;
    use_map_t         use_next;
    rsp_t             rsp_next;
    logic             advance;

    // The held request is resolved whenever the result register can take it.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    dca_select u_select (
        .req         (in_reg),
        .use_map     (use_reg),
        .present_cfg (present_cfg_reg),
        .use_next    (use_next),
        .rsp         (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg     <= 1'b0;
            present_cfg_reg <= PRESENT_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            use_reg         <= '0;
        end else begin
            present_reg <= 1'b1;
            if (cfg_we) begin
                present_cfg_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                use_reg       <= use_next;
            end else if (m_ready && present_reg) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= rsp_next;
        end
    end

endmodule
